// ===== rtl/clsr_pkg.sv =====
// Shared constants, request codes and the controller command type for the
// combined shuffled random number generator. No dependencies.
`default_nettype none

package clsr_pkg;

    localparam int VAL_W      = 31;
    localparam int FRAC_W     = 24;
    localparam int TABLE_SIZE = 32;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int WARM_STEPS = TABLE_SIZE + 8;
    localparam int CNT_W      = $clog2(WARM_STEPS);

    localparam longint TWO31 = 64'h0000_0000_8000_0000;
    localparam longint IM1   = 2147483563;
    localparam longint IM2   = 2147483399;
    localparam longint IMM1  = IM1 - 1;
    localparam longint IA1   = 40014;
    localparam longint IA2   = 40692;

    // Each modulus sits just below 2^31, so 2^31 folds back as a small constant.
    localparam longint FOLD1 = TWO31 - IM1;
    localparam longint FOLD2 = TWO31 - IM2;

    // Slot divisor, and its distance below the next power of two.
    localparam longint NDIV       = 1 + IMM1 / TABLE_SIZE;
    localparam int     SLOT_SHIFT = $clog2(NDIV);
    localparam longint NDIV_DEF   = (longint'(1) << SLOT_SHIFT) - NDIV;
    localparam int     Q0_W       = VAL_W - SLOT_SHIFT;

    localparam int     FRAC_SHIFT = VAL_W - FRAC_W;
    localparam longint FRAC_CAP   = (longint'(1) << FRAC_W) - 2;

    localparam longint FIRST_RESET  = 1;
    localparam longint SECOND_RESET = 123456789;

    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_SEED = 1'b1;

    typedef struct packed {
        logic             load_seed;
        logic             use_input;
        logic             warm_step;
        logic             warm_write;
        logic             warm_last;
        logic [CNT_W-1:0] warm_idx;
        logic             draw_read;
        logic             draw_fin;
        logic             frac_out;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/clsr_if.sv =====
// Valid/ready channel interfaces for request items and result items.
// Depends on clsr_pkg for the field widths.
`default_nettype none

interface clsr_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [clsr_pkg::VAL_W-1:0]  seed_value;

    modport source (output valid, output req_type, output seed_value, input ready);
    modport sink   (input valid, input req_type, input seed_value, output ready);
endinterface

interface clsr_res_if;
    logic                        valid;
    logic                        ready;
    logic [clsr_pkg::VAL_W-1:0]  sample;
    logic [clsr_pkg::FRAC_W-1:0] fraction;
    logic [clsr_pkg::VAL_W-1:0]  first_gen_value;

    modport source (output valid, output sample, output fraction,
                    output first_gen_value, input ready);
    modport sink   (input valid, input sample, input fraction,
                    input first_gen_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/clsr_ctrl.sv =====
// Sequencing state machine: request handshake, warm-up counter, draw phases
// and the result valid flag. Depends on clsr_pkg.
`default_nettype none

module clsr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_req_type,
    output logic               o_in_ready,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output clsr_pkg::t_cmd     o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WARM = 3'd1;
    localparam logic [2:0] ST_DRAW = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_FRAC = 3'd4;

    logic [2:0]                 r_state, n_state;
    logic [clsr_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                       r_seeded, n_seeded;
    logic                       r_out_valid, n_out_valid;
    logic                       w_accept;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_seeded    = r_seeded;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.warm_idx   = r_cnt;
        o_cmd.warm_write = (r_cnt < clsr_pkg::CNT_W'(clsr_pkg::TABLE_SIZE));
        o_cmd.warm_last  = (r_cnt == '0);
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_req_type == clsr_pkg::REQ_DRAW && r_seeded) begin
                        o_cmd.draw_read = 1'b1;
                        n_state         = ST_FIN;
                    end else begin
                        o_cmd.load_seed = 1'b1;
                        o_cmd.use_input = (i_in_req_type == clsr_pkg::REQ_SEED);
                        n_cnt           = clsr_pkg::CNT_W'(clsr_pkg::WARM_STEPS - 1);
                        n_state         = ST_WARM;
                    end
                end
            end
            ST_WARM: begin
                o_cmd.warm_step = 1'b1;
                if (r_cnt == '0) begin
                    n_seeded = 1'b1;
                    n_state  = ST_DRAW;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_DRAW: begin
                o_cmd.draw_read = 1'b1;
                n_state         = ST_FIN;
            end
            ST_FIN: begin
                o_cmd.draw_fin = 1'b1;
                n_state        = ST_FRAC;
            end
            ST_FRAC: begin
                o_cmd.frac_out = 1'b1;
                n_out_valid    = 1'b1;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_seeded    <= n_seeded;
            r_out_valid <= n_out_valid;
        end
    end

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.frac_out |-> !r_out_valid)
        else $error("result written over an item not yet taken");

    a_warm_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WARM && r_cnt == '0) |=> (r_seeded && r_state == ST_DRAW))
        else $error("warm-up did not end in a seeded draw");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE && !o_in_ready))
        else $error("request taken without starting work");

    a_draw_needs_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.draw_read |-> (r_seeded || r_state == ST_DRAW))
        else $error("table read before it was filled");

endmodule

`default_nettype wire

// ===== rtl/clsr_dp.sv =====
// Datapath: both congruential generators, the shuffle table memory, slot
// selection, sample wrap and fraction scaling. Depends on clsr_pkg.
`default_nettype none

module clsr_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire clsr_pkg::t_cmd              i_cmd,
    input  wire logic [clsr_pkg::VAL_W-1:0]  i_seed_value,
    output logic      [clsr_pkg::VAL_W-1:0]  o_sample,
    output logic      [clsr_pkg::FRAC_W-1:0] o_fraction,
    output logic      [clsr_pkg::VAL_W-1:0]  o_first_gen_value
);

    // One multiplicative step: s*a mod m, with 2^31 folded back as (2^31 - m).
    function automatic logic [30:0] f_mcg(input logic [30:0] s, input logic [15:0] a,
                                          input logic [7:0] fold, input logic [30:0] m);
        logic [46:0] p;
        logic [31:0] t;
        p = 47'(s) * 47'(a);
        t = 32'(p[46:31]) * 32'(fold) + 32'(p[30:0]);
        if (t >= 32'(m)) begin
            t = t - 32'(m);
        end
        return t[30:0];
    endfunction

    // Slot = v / NDIV via the shift estimate and one correction, clamped to TABLE_SIZE-1.
    function automatic logic [clsr_pkg::IDX_W-1:0] f_slot(input logic [30:0] v);
        logic [clsr_pkg::Q0_W-1:0]     q0;
        logic [clsr_pkg::SLOT_SHIFT:0] rem;
        logic [clsr_pkg::Q0_W:0]       s;
        q0  = v[30:clsr_pkg::SLOT_SHIFT];
        rem = (clsr_pkg::SLOT_SHIFT+1)'(v[clsr_pkg::SLOT_SHIFT-1:0])
            + (clsr_pkg::SLOT_SHIFT+1)'(q0) * (clsr_pkg::SLOT_SHIFT+1)'(clsr_pkg::NDIV_DEF);
        s   = (clsr_pkg::Q0_W+1)'(q0)
            + (clsr_pkg::Q0_W+1)'(rem >= (clsr_pkg::SLOT_SHIFT+1)'(clsr_pkg::NDIV));
        if (s > (clsr_pkg::Q0_W+1)'(clsr_pkg::TABLE_SIZE - 1)) begin
            s = (clsr_pkg::Q0_W+1)'(clsr_pkg::TABLE_SIZE - 1);
        end
        return s[clsr_pkg::IDX_W-1:0];
    endfunction

    // floor(y * 2^24 / IM1): shift estimate plus one correction, then the cap.
    function automatic logic [clsr_pkg::FRAC_W-1:0] f_frac(input logic [30:0] y);
        logic [clsr_pkg::FRAC_W-1:0] q0;
        logic [32:0]                 r;
        logic [clsr_pkg::FRAC_W:0]   q;
        q0 = y[30:clsr_pkg::FRAC_SHIFT];
        r  = 33'({y[clsr_pkg::FRAC_SHIFT-1:0], {clsr_pkg::FRAC_W{1'b0}}})
           + 33'(q0) * 33'(clsr_pkg::FOLD1);
        q  = (clsr_pkg::FRAC_W+1)'(q0) + (clsr_pkg::FRAC_W+1)'(r >= 33'(clsr_pkg::IM1));
        if (q > (clsr_pkg::FRAC_W+1)'(clsr_pkg::FRAC_CAP)) begin
            q = (clsr_pkg::FRAC_W+1)'(clsr_pkg::FRAC_CAP);
        end
        return q[clsr_pkg::FRAC_W-1:0];
    endfunction

    logic [30:0] r_table [clsr_pkg::TABLE_SIZE];

    logic [30:0]                 r_first, n_first;
    logic [30:0]                 r_second, n_second;
    logic [30:0]                 r_last_out, n_last_out;
    logic [30:0]                 r_rd;
    logic [clsr_pkg::IDX_W-1:0]  r_slot;
    logic [30:0]                 r_sample;
    logic [clsr_pkg::FRAC_W-1:0] r_frac;
    logic [30:0]                 r_fgv;

    logic [30:0]                 w_step1;
    logic [30:0]                 w_step2;
    logic [30:0]                 w_seed;
    logic [clsr_pkg::IDX_W-1:0]  w_slot;
    logic [31:0]                 w_diff;
    logic [30:0]                 w_y;

    assign w_step1 = f_mcg(r_first, 16'(clsr_pkg::IA1), 8'(clsr_pkg::FOLD1),
                           31'(clsr_pkg::IM1));
    assign w_step2 = f_mcg(r_second, 16'(clsr_pkg::IA2), 8'(clsr_pkg::FOLD2),
                           31'(clsr_pkg::IM2));
    assign w_slot  = f_slot(r_last_out);

    always_comb begin
        w_seed = i_cmd.use_input ? i_seed_value : r_first;
        if (w_seed == '0) begin
            w_seed = 31'd1;
        end
    end

    always_comb begin
        w_diff = {1'b0, r_rd} - {1'b0, r_second};
        if (w_diff[31] || w_diff == '0) begin
            w_diff = w_diff + 32'(clsr_pkg::IMM1);
        end
        w_y = w_diff[30:0];
    end

    always_comb begin
        n_first    = r_first;
        n_second   = r_second;
        n_last_out = r_last_out;
        if (i_cmd.load_seed) begin
            n_first  = w_seed;
            n_second = w_seed;
        end else if (i_cmd.warm_step) begin
            n_first = w_step1;
            if (i_cmd.warm_last) begin
                n_last_out = w_step1;
            end
        end else if (i_cmd.draw_read) begin
            n_first  = w_step1;
            n_second = w_step2;
        end else if (i_cmd.draw_fin) begin
            n_last_out = w_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first    <= 31'(clsr_pkg::FIRST_RESET);
            r_second   <= 31'(clsr_pkg::SECOND_RESET);
            r_last_out <= '0;
        end else begin
            r_first    <= n_first;
            r_second   <= n_second;
            r_last_out <= n_last_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.warm_step && i_cmd.warm_write) begin
            r_table[i_cmd.warm_idx[clsr_pkg::IDX_W-1:0]] <= w_step1;
        end else if (i_cmd.draw_fin) begin
            r_table[r_slot] <= r_first;
        end
        if (i_cmd.draw_read) begin
            r_rd   <= r_table[w_slot];
            r_slot <= w_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.frac_out) begin
            r_sample <= r_last_out;
            r_frac   <= f_frac(r_last_out);
            r_fgv    <= r_first;
        end
    end

    assign o_sample          = r_sample;
    assign o_fraction        = r_frac;
    assign o_first_gen_value = r_fgv;

    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.draw_fin |=> (r_last_out != '0 && r_last_out < 31'(clsr_pkg::IM1)))
        else $error("sample left the range 1..IM1-1");

    a_gen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.draw_read |=> (r_first < 31'(clsr_pkg::IM1)
                             && r_second < 31'(clsr_pkg::IM2)))
        else $error("generator state not reduced below its modulus");

    a_frac_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.frac_out |=> (r_frac <= clsr_pkg::FRAC_W'(clsr_pkg::FRAC_CAP)
                            && r_sample == $past(r_last_out)))
        else $error("result register not loaded as expected");

endmodule

`default_nettype wire

// ===== rtl/combined_lcg_shuffled_rng.sv =====
// Draw item: registered read and write-back of the single-port shuffle table,
// then the result register; no new item is taken until the draw has finished.
// Seed item, or the first draw after reset: a seed load, 40 warm-up steps
// of the first generator's step unit, then the draw.
// Reset is synchronous and active low; it restores the reset seed and marks the
// generator unseeded, so the first draw fills the table first.
`default_nettype none

module combined_lcg_shuffled_rng (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    clsr_req_if.sink  i_req,
    clsr_res_if.source o_res
);

    clsr_pkg::t_cmd w_cmd;

    clsr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_req.valid),
        .i_in_req_type (i_req.req_type),
        .o_in_ready    (i_req.ready),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_cmd         (w_cmd)
    );

    clsr_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_seed_value      (i_req.seed_value),
        .o_sample          (o_res.sample),
        .o_fraction        (o_res.fraction),
        .o_first_gen_value (o_res.first_gen_value)
    );

endmodule

`default_nettype wire
